>>> hdl/vhsu_pkg.sv
// Shared types, constants and arithmetic helpers for the Verlet half-step update block.
package vhsu_pkg;

   localparam int unsigned ATOMS_DEFAULT = 1024;
   localparam int unsigned FIFO_DEPTH    = 8;

   localparam logic [1:0] CSR_STEP_TIME  = 2'd0;
   localparam logic [1:0] CSR_HALF_STEP  = 2'd1;
   localparam logic [1:0] CSR_SKIN_LIMIT = 2'd2;

   typedef enum logic [1:0] {
      FUNC_STEP       = 2'd0,
      FUNC_LOAD_POS   = 2'd1,
      FUNC_LOAD_VEL   = 2'd2,
      FUNC_CLEAR_DISP = 2'd3
   } func_type;

   typedef logic [2:0][31:0] vec3_type;

   typedef struct packed {
      vec3_type pos;
      vec3_type vel;
      vec3_type disp;
   } row_type;

   typedef struct packed {
      func_type         func;
      logic [9:0]       atom;
      logic             in_range;
      logic             pass_start;
      vec3_type         value;
      vec3_type         pos_old;
      vec3_type         vel_old;
      vec3_type         disp_old;
      vec3_type         vel_new;
      vec3_type         pos_new;
      vec3_type         move;
      vec3_type         disp_new;
      logic [2:0][63:0] prod;
   } item_type;

   typedef struct packed {
      logic [9:0]  atom;
      vec3_type    pos;
      vec3_type    vel;
      logic        moved;
      logic [10:0] count;
   } result_type;

   // Magnitude of a two's complement word; the most negative value maps to 2^31.
   function automatic logic [31:0] abs32(input logic [31:0] a);
      return a[31] ? (~a + 32'd1) : a;
   endfunction

   // Rounds a Q32.32 magnitude to Q16.16 (ties away from zero), applies the sign,
   // adds it to base and saturates to the signed 32-bit range.
   function automatic logic [31:0] round_add_sat(input logic [31:0] base,
                                                 input logic [63:0] prod,
                                                 input logic        neg);
      logic [64:0]        rs;
      logic [48:0]        mag;
      logic signed [50:0] term;
      logic signed [50:0] sum;
      logic [31:0]        res;
      rs   = {1'b0, prod} + 65'h8000;
      mag  = rs[64:16];
      term = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      sum  = term + $signed({{19{base[31]}}, base});
      if (sum > 51'sd2147483647) begin
         res = 32'h7FFF_FFFF;
      end else if (sum < -51'sd2147483648) begin
         res = 32'h8000_0000;
      end else begin
         res = sum[31:0];
      end
      return res;
   endfunction

   // Absolute difference of two signed words; always fits in 32 unsigned bits.
   function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      if (d[32]) begin
         d = ~d + 33'd1;
      end
      return d[31:0];
   endfunction

   // Unsigned add saturating at all ones.
   function automatic logic [31:0] add_sat_u32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

>>> hdl/verlet_half_step_update.sv
// Top level of the Verlet half-step update block: atom state memory, update pipeline, result queue.
//
// The block takes one request per clock, unless the atom interlock or the credit count holds
// it, and answers each with one response, in order. A step request (force vector) adds
// half_step_over_mass times force to the atom's velocity, then step_time times the new
// velocity to its position, adds the per-axis absolute moves to the displacement sums and
// flags the atom when the squared length of those sums exceeds skin_limit_sq; flagged atoms
// are counted per pass, and pass_start clears the count first. Load requests overwrite
// position or velocity, and a clear request zeroes the sums. All atom state lives in one
// memory row per atom with a single read port and a single write port; a row is read when a
// request is accepted and written back from stage 5, and the response enters the queue from
// stage 6. A request for an atom that is still in the first five pipeline stages waits until
// that earlier write-back is done, so requests that revisit one atom are held back, while
// distinct atoms stream at one per cycle as long as credits remain. An eight-entry response
// queue, with credit counting across pipeline and queue, lets the block keep accepting
// requests while finished responses wait to be taken. Atom memory contents are undefined
// after reset until loaded, so no clearing pass is needed; software loads position and
// velocity and clears the sums before stepping an atom.
module verlet_half_step_update #(
   parameter int unsigned ATOMS = vhsu_pkg::ATOMS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [9:0]         req_atom,
   input  logic signed [31:0] req_value_x,
   input  logic signed [31:0] req_value_y,
   input  logic signed [31:0] req_value_z,
   input  logic               req_pass_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_atom_out,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_pos_z,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   output logic               rsp_moved_too_far,
   output logic [10:0]        rsp_refresh_count
);
   import vhsu_pkg::*;

   localparam int unsigned AW = (ATOMS > 1) ? $clog2(ATOMS) : 1;
   localparam int unsigned PW = $clog2(FIFO_DEPTH);
   localparam int unsigned CW = PW + 1;

   // Configuration registers.
   logic [31:0] step_time_ff, half_step_ff, skin_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff  <= '0;
         half_step_ff  <= '0;
         skin_limit_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_TIME:  step_time_ff  <= csr_wdata;
            CSR_HALF_STEP:  half_step_ff  <= csr_wdata;
            CSR_SKIN_LIMIT: skin_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline stage registers; stage 1 holds a request accepted on the previous edge.
   item_type   st_ff [1:6];
   item_type   st_in [1:6];
   logic [6:1] vld_ff;

   logic       req_fire, hazard, pop;
   logic       flag;
   logic [10:0] flag_cnt_ff, flag_cnt_in;
   result_type res;

   // Atom state memory: one row per atom, read at accept, written back from stage 5.
   row_type mem [ATOMS];
   row_type rd_ff;
   row_type wr_row;
   logic    wr_en;

   always_ff @(posedge clock) begin
      rd_ff <= mem[AW'(req_atom)];
      if (wr_en) begin
         mem[AW'(st_ff[5].atom)] <= wr_row;
      end
   end

   // A request may not read a row that an older request in stages 1 to 5 still has to write.
   always_comb begin
      hazard = 1'b0;
      for (int k = 1; k <= 5; k++) begin
         if (vld_ff[k] && st_ff[k].in_range && (st_ff[k].atom == req_atom)) begin
            hazard = 1'b1;
         end
      end
   end

   logic [CW-1:0] credit_ff;
   assign req_ready = (credit_ff < CW'(FIFO_DEPTH)) && !hazard;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      st_in[1]            = '0;
      st_in[1].func       = func_type'(req_func);
      st_in[1].atom       = req_atom;
      st_in[1].in_range   = (32'(req_atom) < ATOMS);
      st_in[1].pass_start = req_pass_start;
      st_in[1].value      = {req_value_z, req_value_y, req_value_x};

      // Stage 1: capture the row and form force times half_step_over_mass.
      st_in[2]          = st_ff[1];
      st_in[2].pos_old  = rd_ff.pos;
      st_in[2].vel_old  = rd_ff.vel;
      st_in[2].disp_old = rd_ff.disp;
      for (int i = 0; i < 3; i++) begin
         st_in[2].prod[i] = 64'(abs32(st_ff[1].value[i])) * 64'(half_step_ff);
      end

      // Stage 2: new velocity.
      st_in[3] = st_ff[2];
      for (int i = 0; i < 3; i++) begin
         st_in[3].vel_new[i] = round_add_sat(st_ff[2].vel_old[i], st_ff[2].prod[i],
                                             st_ff[2].value[i][31]);
      end

      // Stage 3: velocity times step_time.
      st_in[4] = st_ff[3];
      for (int i = 0; i < 3; i++) begin
         st_in[4].prod[i] = 64'(abs32(st_ff[3].vel_new[i])) * 64'(step_time_ff);
      end

      // Stage 4: new position and the absolute move on each axis.
      st_in[5] = st_ff[4];
      for (int i = 0; i < 3; i++) begin
         st_in[5].pos_new[i] = round_add_sat(st_ff[4].pos_old[i], st_ff[4].prod[i],
                                             st_ff[4].vel_new[i][31]);
         st_in[5].move[i]    = abs_diff(st_in[5].pos_new[i], st_ff[4].pos_old[i]);
      end

      // Stage 5: displacement sums, request kind, write-back and squares of the sums.
      st_in[6] = st_ff[5];
      for (int i = 0; i < 3; i++) begin
         st_in[6].disp_new[i] = add_sat_u32(st_ff[5].disp_old[i], st_ff[5].move[i]);
      end
      case (st_ff[5].func)
         FUNC_STEP: ;
         FUNC_LOAD_POS: begin
            st_in[6].pos_new  = st_ff[5].value;
            st_in[6].vel_new  = st_ff[5].vel_old;
            st_in[6].disp_new = st_ff[5].disp_old;
         end
         FUNC_LOAD_VEL: begin
            st_in[6].pos_new  = st_ff[5].pos_old;
            st_in[6].vel_new  = st_ff[5].value;
            st_in[6].disp_new = st_ff[5].disp_old;
         end
         FUNC_CLEAR_DISP: begin
            st_in[6].pos_new  = st_ff[5].pos_old;
            st_in[6].vel_new  = st_ff[5].vel_old;
            st_in[6].disp_new = '0;
         end
         default: ;
      endcase
      for (int i = 0; i < 3; i++) begin
         st_in[6].prod[i] = 64'(st_in[6].disp_new[i]) * 64'(st_in[6].disp_new[i]);
      end
   end

   assign wr_en       = vld_ff[5] && st_ff[5].in_range;
   assign wr_row.pos  = st_in[6].pos_new;
   assign wr_row.vel  = st_in[6].vel_new;
   assign wr_row.disp = st_in[6].disp_new;

   always_ff @(posedge clock) begin
      for (int k = 1; k <= 6; k++) begin
         st_ff[k] <= st_in[k];
      end
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:1], req_fire};
      end
   end

   // Stage 6: skin test on the exact sum of squares, then the per-pass counter.
   logic [65:0] sq_sum;
   always_comb begin
      sq_sum = 66'(st_ff[6].prod[0]) + 66'(st_ff[6].prod[1]) + 66'(st_ff[6].prod[2]);
      flag   = st_ff[6].in_range && (st_ff[6].func == FUNC_STEP) &&
               (sq_sum > {18'd0, skin_limit_ff, 16'd0});
      flag_cnt_in = st_ff[6].pass_start ? 11'd0 : flag_cnt_ff;
      if (flag && (flag_cnt_in != 11'h7FF)) begin
         flag_cnt_in = flag_cnt_in + 11'd1;
      end
      res.atom  = st_ff[6].atom;
      res.pos   = st_ff[6].in_range ? st_ff[6].pos_new : '0;
      res.vel   = st_ff[6].in_range ? st_ff[6].vel_new : '0;
      res.moved = flag;
      res.count = flag_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_cnt_ff <= '0;
      end else if (vld_ff[6]) begin
         flag_cnt_ff <= flag_cnt_in;
      end
   end

   // Response queue; credits cover both the pipeline and the queue, so it cannot overflow.
   result_type    fifo_mem [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] fill_ff;

   assign rsp_valid = (fill_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (vld_ff[6]) begin
         fifo_mem[wr_ptr_ff] <= res;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         if (vld_ff[6]) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         fill_ff   <= fill_ff + CW'(vld_ff[6]) - CW'(pop);
         credit_ff <= credit_ff + CW'(req_fire) - CW'(pop);
      end
   end

   assign rsp_atom_out      = fifo_mem[rd_ptr_ff].atom;
   assign rsp_new_pos_x     = fifo_mem[rd_ptr_ff].pos[0];
   assign rsp_new_pos_y     = fifo_mem[rd_ptr_ff].pos[1];
   assign rsp_new_pos_z     = fifo_mem[rd_ptr_ff].pos[2];
   assign rsp_new_vel_x     = fifo_mem[rd_ptr_ff].vel[0];
   assign rsp_new_vel_y     = fifo_mem[rd_ptr_ff].vel[1];
   assign rsp_new_vel_z     = fifo_mem[rd_ptr_ff].vel[2];
   assign rsp_moved_too_far = fifo_mem[rd_ptr_ff].moved;
   assign rsp_refresh_count = fifo_mem[rd_ptr_ff].count;

   // The credit count never exceeds the queue depth.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CW'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   // The queue never receives a response while full and not being drained.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(vld_ff[6] && (fill_ff == CW'(FIFO_DEPTH)) && !pop))
      else $error("response queue overflow");

   // The interlock keeps two in-flight requests for one atom out of stages 1 and 2 at once.
   a_no_same_atom: assert property (@(posedge clock) disable iff (reset)
      !(vld_ff[1] && vld_ff[2] && st_ff[1].in_range && st_ff[2].in_range &&
        (st_ff[1].atom == st_ff[2].atom)))
      else $error("two in-flight requests for one atom");

   // Every valid stage-5 item reaches stage 6 in the next cycle.
   a_push_follows: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |=> vld_ff[6])
      else $error("pipeline lost an item");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the Verlet half-step update block.
module testbench;
   import vhsu_pkg::*;

   localparam int unsigned NUM_ATOMS   = 1024;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned DRAIN_WAIT  = 20;

   // Every input of the block is given a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [9:0]  req_atom = '0;
   logic signed [31:0] req_value_x = '0;
   logic signed [31:0] req_value_y = '0;
   logic signed [31:0] req_value_z = '0;
   logic        req_pass_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [9:0]  rsp_atom_out;
   logic signed [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z;
   logic signed [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic        rsp_moved_too_far;
   logic [10:0] rsp_refresh_count;

   verlet_half_step_update i_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_atom(req_atom), .req_value_x(req_value_x), .req_value_y(req_value_y),
      .req_value_z(req_value_z), .req_pass_start(req_pass_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_atom_out(rsp_atom_out),
      .rsp_new_pos_x(rsp_new_pos_x), .rsp_new_pos_y(rsp_new_pos_y),
      .rsp_new_pos_z(rsp_new_pos_z), .rsp_new_vel_x(rsp_new_vel_x),
      .rsp_new_vel_y(rsp_new_vel_y), .rsp_new_vel_z(rsp_new_vel_z),
      .rsp_moved_too_far(rsp_moved_too_far), .rsp_refresh_count(rsp_refresh_count)
   );

   // One expected response. Position or velocity of an atom that was never loaded is
   // undefined in the block, so those fields carry a flag saying whether they are known.
   typedef struct {
      logic [9:0]  atom;
      int          pos[3];
      int          vel[3];
      bit          pos_known;
      bit          vel_known;
      bit          moved;
      logic [10:0] count;
   } atom_update_type;

   atom_update_type pending_updates[$];

   // Shadow copy of the block's registers and atom state.
   int unsigned dt_reg, half_step_reg, skin_sq_reg;
   int          pos_shadow[NUM_ATOMS][3];
   int          vel_shadow[NUM_ATOMS][3];
   int unsigned disp_shadow[NUM_ATOMS][3];
   bit          pos_loaded[NUM_ATOMS];
   bit          vel_loaded[NUM_ATOMS];
   bit          disp_cleared[NUM_ATOMS];
   int unsigned flagged_atoms;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          no_idle = 1'b0;   // when set, neither side inserts gaps or stalls
   int unsigned rsp_stall = 0;

   // Clock with a period of ten time units.
   initial begin
      forever #5 clock = ~clock;
   end

   // The run is cut off if it ever takes far longer than the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("verlet_half_step_update: mismatch");
         $finish;
      end
   end

   function automatic int unsigned idle_draw();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Fixed-point arithmetic of the predictor.
   // ---------------------------------------------------------------------------------------

   function automatic int sat_q16(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
      return int'(v);
   endfunction

   // Signed Q16.16 times unsigned Q16.16, rounded to nearest with ties away from zero.
   function automatic longint scale_q16(int a, int unsigned b);
      longint unsigned mag;
      longint unsigned r;
      mag = (a < 0) ? longint'(-longint'(a)) : longint'(a);
      r   = (mag * longint'(b) + 64'h8000) >> 16;
      return (a < 0) ? -longint'(r) : longint'(r);
   endfunction

   // The skin test compares the exact Q32.32 sum of squared displacements with the limit.
   function automatic bit outside_skin(int unsigned dx, int unsigned dy, int unsigned dz);
      longint unsigned sx, sy, sz, low, hi;
      sx  = longint'(dx) * longint'(dx);
      sy  = longint'(dy) * longint'(dy);
      sz  = longint'(dz) * longint'(dz);
      low = (sx & 64'hFFFF) + (sy & 64'hFFFF) + (sz & 64'hFFFF);
      hi  = (sx >> 16) + (sy >> 16) + (sz >> 16) + (low >> 16);
      if (hi > longint'(skin_sq_reg)) return 1'b1;
      return (hi == longint'(skin_sq_reg)) && ((low & 64'hFFFF) != 0);
   endfunction

   // Works out the response of one accepted request and advances the shadow state.
   function automatic atom_update_type predict_update(func_type func, logic [9:0] atom,
                                                      int value[3], bit pass_start);
      atom_update_type u;
      int              new_vel, new_pos;
      longint          move;
      longint unsigned total;
      if (pass_start) flagged_atoms = 0;
      u.moved = 1'b0;
      case (func)
         FUNC_STEP: begin
            for (int a = 0; a < 3; a++) begin
               new_vel = sat_q16(longint'(vel_shadow[atom][a]) +
                                 scale_q16(value[a], half_step_reg));
               new_pos = sat_q16(longint'(pos_shadow[atom][a]) +
                                 scale_q16(new_vel, dt_reg));
               move = longint'(new_pos) - longint'(pos_shadow[atom][a]);
               if (move < 0) move = -move;
               total = longint'(disp_shadow[atom][a]) + move;
               if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
               vel_shadow[atom][a]  = new_vel;
               pos_shadow[atom][a]  = new_pos;
               disp_shadow[atom][a] = total[31:0];
            end
            u.moved = outside_skin(disp_shadow[atom][0], disp_shadow[atom][1],
                                   disp_shadow[atom][2]);
            if (u.moved && flagged_atoms < 2047) flagged_atoms++;
         end
         FUNC_LOAD_POS: begin
            for (int a = 0; a < 3; a++) pos_shadow[atom][a] = value[a];
            pos_loaded[atom] = 1'b1;
         end
         FUNC_LOAD_VEL: begin
            for (int a = 0; a < 3; a++) vel_shadow[atom][a] = value[a];
            vel_loaded[atom] = 1'b1;
         end
         default: begin
            for (int a = 0; a < 3; a++) disp_shadow[atom][a] = 0;
            disp_cleared[atom] = 1'b1;
         end
      endcase
      u.atom      = atom;
      u.pos       = pos_shadow[atom];
      u.vel       = vel_shadow[atom];
      u.pos_known = pos_loaded[atom];
      u.vel_known = vel_loaded[atom];
      u.count     = flagged_atoms[10:0];
      return u;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driving and checking.
   // ---------------------------------------------------------------------------------------

   task automatic write_csr(logic [1:0] index, logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      // Indexes past the last register are ignored by the block.
      case (index)
         CSR_STEP_TIME:  dt_reg        = data;
         CSR_HALF_STEP:  half_step_reg = data;
         CSR_SKIN_LIMIT: skin_sq_reg   = data;
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned dt, int unsigned half_step, int unsigned skin_sq);
      write_csr(CSR_STEP_TIME, dt);
      write_csr(CSR_HALF_STEP, half_step);
      write_csr(CSR_SKIN_LIMIT, skin_sq);
   endtask

   // Sends one request. Valid stays high from one request to the next unless a gap is drawn,
   // so it is never lowered and raised within one time step.
   task automatic send_request(func_type func, logic [9:0] atom,
                               int x, int y, int z, bit pass_start);
      int unsigned  gap;
      int           value[3];
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_atom       <= atom;
      req_value_x    <= x;
      req_value_y    <= y;
      req_value_z    <= z;
      req_pass_start <= pass_start;
      do @(posedge clock); while (!req_ready);
      value = '{x, y, z};
      pending_updates.push_back(predict_update(func, atom, value, pass_start));
   endtask

   // Lowers valid and waits until every expected response has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("error: response field %s is %0h, expected %0h", field, got, want);
      error_count++;
   endtask

   // The result side stalls for a freshly drawn number of cycles after each response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_stall = idle_draw();
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // Each accepted response is compared with the oldest expectation.
   always @(posedge clock) begin
      atom_update_type want;
      int              got_pos[3];
      int              got_vel[3];
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_updates.size() == 0) begin
            $display("error: response for atom %0d with no request outstanding", rsp_atom_out);
            error_count++;
         end else begin
            want    = pending_updates.pop_front();
            got_pos = '{rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z};
            got_vel = '{rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z};
            if (rsp_atom_out !== want.atom) report_mismatch("atom_out", rsp_atom_out, want.atom);
            for (int a = 0; a < 3; a++) begin
               if (want.pos_known && got_pos[a] !== want.pos[a])
                  report_mismatch($sformatf("new_pos[%0d]", a), got_pos[a], want.pos[a]);
               if (want.vel_known && got_vel[a] !== want.vel[a])
                  report_mismatch($sformatf("new_vel[%0d]", a), got_vel[a], want.vel[a]);
            end
            if (rsp_moved_too_far !== want.moved)
               report_mismatch("moved_too_far", rsp_moved_too_far, want.moved);
            if (rsp_refresh_count !== want.count)
               report_mismatch("refresh_count", rsp_refresh_count, want.count);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Mostly moderate values, with some full-range words and the extremes mixed in.
   function automatic int draw_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 0;
         3, 4:    return $urandom;
         default: return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      endcase
   endfunction

   // Extremes of every field, every operation, saturation of position, velocity and the
   // displacement sums, and a write to the unused register index.
   task automatic test_directed();
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      write_csr(2'd3, 32'hFFFF_FFFF);
      // A clear on a fresh atom has unknown position and velocity; only the rest is checked.
      send_request(FUNC_CLEAR_DISP, 10'd1023, 0, 0, 0, 1'b1);
      send_request(FUNC_LOAD_POS, 10'd1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b0);
      send_request(FUNC_LOAD_VEL, 10'd1023, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 1'b0);
      send_request(FUNC_STEP, 10'd1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      send_request(FUNC_STEP, 10'd1023, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
      send_request(FUNC_STEP, 10'd1023, 0, 0, 0, 1'b0);
      send_request(FUNC_LOAD_POS, 10'd0, 0, 0, 0, 1'b0);
      send_request(FUNC_LOAD_VEL, 10'd0, 0, 0, 0, 1'b0);
      send_request(FUNC_CLEAR_DISP, 10'd0, 0, 0, 0, 1'b0);
      send_request(FUNC_STEP, 10'd0, 0, 0, 0, 1'b1);
      send_request(FUNC_STEP, 10'd0, 1, -1, 32'sh0000_8000, 1'b0);
      drain();
      // Rounding ties and a limit that is met exactly rather than exceeded.
      configure(32'h0000_8000, 32'h0000_8000, 32'h0000_0001);
      send_request(FUNC_LOAD_POS, 10'd0, 0, 0, 0, 1'b0);
      send_request(FUNC_LOAD_VEL, 10'd0, 0, 0, 0, 1'b0);
      send_request(FUNC_CLEAR_DISP, 10'd0, 0, 0, 0, 1'b0);
      send_request(FUNC_STEP, 10'd0, 32'sh0000_0004, 0, 0, 1'b0);
      send_request(FUNC_STEP, 10'd0, -32'sh0000_0003, 32'sh0000_0001, 0, 1'b1);
      send_request(FUNC_STEP, 10'd0, 32'sh0000_0100, 0, 0, 1'b0);
      drain();
      configure(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(FUNC_STEP, 10'd1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b1);
      send_request(FUNC_STEP, 10'd0, $urandom, $urandom, $urandom, 1'b0);
      drain();
   endtask

   // Phases of random requests, each under its own register setting, with a mix of atoms
   // that are revisited back to back and atoms spread over the whole index range.
   task automatic test_random(int unsigned num_items);
      int unsigned done, phase_len;
      logic [9:0]  atom;
      func_type    func;
      done = 0;
      while (done < num_items) begin
         case ($urandom_range(0, 4))
            0:       configure($urandom, $urandom, $urandom);
            1:       configure(32'hFFFF_FFFF, $urandom_range(0, 32'h2_0000), 32'hFFFF_FFFF);
            default: configure($urandom_range(0, 32'h2_0000), $urandom_range(0, 32'h1_0000),
                               $urandom_range(0, 32'h40_0000));
         endcase
         no_idle   = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(60, 200);
         for (int i = 0; i < phase_len; i++) begin
            atom = ($urandom_range(0, 4) != 0) ? 10'($urandom_range(0, 15))
                                               : 10'($urandom_range(0, NUM_ATOMS - 1));
            func = ($urandom_range(0, 9) < 7) ? FUNC_STEP : func_type'($urandom_range(1, 3));
            // A step reads every part of the atom's state, so a fresh atom is loaded first.
            if (func == FUNC_STEP) begin
               if (!pos_loaded[atom])        func = FUNC_LOAD_POS;
               else if (!vel_loaded[atom])   func = FUNC_LOAD_VEL;
               else if (!disp_cleared[atom]) func = FUNC_CLEAR_DISP;
            end
            send_request(func, atom, draw_value(), draw_value(), draw_value(),
                         $urandom_range(0, 31) == 0);
         end
         done += phase_len;
         drain();
      end
      no_idle = 1'b0;
   endtask

   // A long run of flagged steps that opens a pass, streamed over eight atoms so that the
   // counter climbs at one per cycle, then a pass start that clears it.
   task automatic test_counter_run();
      configure(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
      for (int a = 0; a < 8; a++) begin
         send_request(FUNC_LOAD_POS, 10'(a), 0, 0, 0, 1'b0);
         send_request(FUNC_LOAD_VEL, 10'(a), 32'sh0001_0000, -32'sh0000_4000, 1, 1'b0);
         send_request(FUNC_CLEAR_DISP, 10'(a), 0, 0, 0, 1'b0);
      end
      no_idle = 1'b1;
      for (int i = 0; i < 300; i++) begin
         send_request(FUNC_STEP, 10'(i % 8), $urandom, $urandom, $urandom, i == 0);
      end
      send_request(FUNC_STEP, 10'd3, 0, 0, 0, 1'b1);
      no_idle = 1'b0;
      drain();
   endtask

   initial begin
      dt_reg        = 0;
      half_step_reg = 0;
      skin_sq_reg   = 0;
      flagged_atoms = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(850);
      test_counter_run();
      if (error_count == 0) begin
         $display("verlet_half_step_update: match");
      end else begin
         $display("verlet_half_step_update: mismatch");
      end
      $finish;
   end

endmodule
